[rtl/adsr_env_pkg.sv]
// shared widths, types, codes and reset values for the adsr envelope level block
package adsr_env_pkg;

    localparam int INDEX_BITS      = 20;
    localparam int LEVEL_FRAC_BITS = 16;

    localparam int IDX_W  = INDEX_BITS;
    localparam int LVL_W  = LEVEL_FRAC_BITS + 1;
    localparam int LEN_W  = 18;
    localparam int X_W    = (IDX_W > LEN_W) ? IDX_W : LEN_W;
    localparam int NUM_W  = LVL_W + LEN_W;
    localparam int QUO_W  = LVL_W;
    localparam int CFG_W0 = (IDX_W > LEN_W) ? IDX_W : LEN_W;
    localparam int CFG_W  = (CFG_W0 > LVL_W) ? CFG_W0 : LVL_W;
    localparam int ADDR_W = 3;

    // front 2, scaler 1, divider QUO_W+1, mid 1, scaler 1, divider QUO_W+1
    localparam int PIPE_LAT = 2 * QUO_W + 7;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [LVL_W-1:0] lvl_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [X_W-1:0]   xval_t;
    typedef logic [NUM_W-1:0] num_t;

    localparam lvl_t LEVEL_ONE = lvl_t'(1) << LEVEL_FRAC_BITS;

    localparam len_t ATTACK_RST  = len_t'(320);
    localparam len_t DECAY_RST   = len_t'(3200);
    localparam len_t RELEASE_RST = len_t'(6400);
    localparam lvl_t SUSTAIN_RST = lvl_t'(0);
    localparam idx_t GATE_RST    = idx_t'(0);

    typedef enum logic [2:0] {
        PH_ATTACK  = 3'd0,
        PH_DECAY   = 3'd1,
        PH_SUSTAIN = 3'd2,
        PH_RELEASE = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    typedef enum logic [ADDR_W-1:0] {
        CFG_ATTACK_LEN  = 3'd0,
        CFG_DECAY_LEN   = 3'd1,
        CFG_RELEASE_LEN = 3'd2,
        CFG_SUSTAIN     = 3'd3,
        CFG_GATE_OFF    = 3'd4
    } cfg_addr_t;

    // lengths are held nonzero and sustain clamped to full scale
    typedef struct packed {
        len_t attack;
        len_t decay;
        len_t rel_len;
        lvl_t sustain;
        idx_t gate;
    } cfg_t;

    // sideband that rides along with each item
    typedef struct packed {
        phase_t phase;
        phase_t hseg;
        len_t   rel_left;
    } tag_t;

endpackage

[rtl/adsr_env_front.sv]
// segment decode and multiplier operand select, two register stages
module adsr_env_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  adsr_env_pkg::idx_t  in_index,
    input  adsr_env_pkg::cfg_t  cfg,
    output logic                out_valid,
    output adsr_env_pkg::lvl_t  out_a,
    output adsr_env_pkg::len_t  out_b,
    output adsr_env_pkg::len_t  out_dv,
    output adsr_env_pkg::tag_t  out_tag
);

    // stage 1
    logic                s1_vld_reg;
    logic                s1_ltg_reg;
    adsr_env_pkg::idx_t  s1_rel_reg;
    adsr_env_pkg::xval_t s1_x_reg;
    logic                s1_xlta_reg;
    adsr_env_pkg::xval_t s1_xa_reg;

    adsr_env_pkg::xval_t i_ext;
    adsr_env_pkg::xval_t g_ext;
    adsr_env_pkg::xval_t a_ext;
    logic                ltg;
    logic                i_lta;
    logic                g_lta;
    adsr_env_pkg::xval_t i_ma;
    adsr_env_pkg::xval_t g_ma;

    assign i_ext = adsr_env_pkg::xval_t'(in_index);
    assign g_ext = adsr_env_pkg::xval_t'(cfg.gate);
    assign a_ext = adsr_env_pkg::xval_t'(cfg.attack);
    assign ltg   = in_index < cfg.gate;
    assign i_lta = i_ext < a_ext;
    assign g_lta = g_ext < a_ext;
    assign i_ma  = i_ext - a_ext;
    assign g_ma  = g_ext - a_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ltg_reg  <= ltg;
        s1_rel_reg  <= in_index - cfg.gate;
        s1_x_reg    <= ltg ? i_ext : g_ext;
        s1_xlta_reg <= ltg ? i_lta : g_lta;
        s1_xa_reg   <= ltg ? i_ma : g_ma;
    end

    // stage 2
    logic                s2_vld_reg;
    adsr_env_pkg::lvl_t  s2_a_reg;
    adsr_env_pkg::len_t  s2_b_reg;
    adsr_env_pkg::len_t  s2_dv_reg;
    adsr_env_pkg::tag_t  s2_tag_reg;

    adsr_env_pkg::lvl_t  a_next;
    adsr_env_pkg::len_t  b_next;
    adsr_env_pkg::len_t  dv_next;
    adsr_env_pkg::tag_t  tag_next;
    adsr_env_pkg::phase_t hseg;
    adsr_env_pkg::xval_t rel_ext;
    adsr_env_pkg::xval_t rel_diff;
    logic                in_dec;
    logic                rel_live;

    assign in_dec   = s1_xa_reg < adsr_env_pkg::xval_t'(cfg.decay);
    assign rel_ext  = adsr_env_pkg::xval_t'(s1_rel_reg);
    assign rel_live = rel_ext < adsr_env_pkg::xval_t'(cfg.rel_len);
    assign rel_diff = adsr_env_pkg::xval_t'(cfg.rel_len) - rel_ext;

    always_comb
    begin
        priority if (s1_xlta_reg)
        begin
            hseg    = adsr_env_pkg::PH_ATTACK;
            a_next  = adsr_env_pkg::LEVEL_ONE;
            b_next  = s1_x_reg[adsr_env_pkg::LEN_W-1:0];
            dv_next = cfg.attack;
        end
        else if (in_dec)
        begin
            hseg    = adsr_env_pkg::PH_DECAY;
            a_next  = adsr_env_pkg::LEVEL_ONE - cfg.sustain;
            b_next  = s1_xa_reg[adsr_env_pkg::LEN_W-1:0];
            dv_next = cfg.decay;
        end
        else
        begin
            hseg    = adsr_env_pkg::PH_SUSTAIN;
            a_next  = cfg.sustain;
            b_next  = adsr_env_pkg::len_t'(1);
            dv_next = adsr_env_pkg::len_t'(1);
        end
    end

    always_comb
    begin
        tag_next.hseg     = hseg;
        tag_next.rel_left = rel_diff[adsr_env_pkg::LEN_W-1:0];
        priority if (s1_ltg_reg)
        begin
            tag_next.phase = hseg;
        end
        else if (rel_live)
        begin
            tag_next.phase = adsr_env_pkg::PH_RELEASE;
        end
        else
        begin
            tag_next.phase = adsr_env_pkg::PH_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_a_reg   <= a_next;
        s2_b_reg   <= b_next;
        s2_dv_reg  <= dv_next;
        s2_tag_reg <= tag_next;
    end

    assign out_valid = s2_vld_reg;
    assign out_a     = s2_a_reg;
    assign out_b     = s2_b_reg;
    assign out_dv    = s2_dv_reg;
    assign out_tag   = s2_tag_reg;

endmodule

[rtl/adsr_env_scale.sv]
// one registered multiply stage that forms a dividend
module adsr_env_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  adsr_env_pkg::lvl_t  in_a,
    input  adsr_env_pkg::len_t  in_b,
    input  adsr_env_pkg::len_t  in_dv,
    input  adsr_env_pkg::tag_t  in_tag,
    output logic                out_valid,
    output adsr_env_pkg::num_t  out_num,
    output adsr_env_pkg::len_t  out_dv,
    output adsr_env_pkg::tag_t  out_tag
);

    logic               vld_reg;
    adsr_env_pkg::num_t num_reg;
    adsr_env_pkg::len_t dv_reg;
    adsr_env_pkg::tag_t tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= adsr_env_pkg::num_t'(in_a) * adsr_env_pkg::num_t'(in_b);
        dv_reg  <= in_dv;
        tag_reg <= in_tag;
    end

    assign out_valid = vld_reg;
    assign out_num   = num_reg;
    assign out_dv    = dv_reg;
    assign out_tag   = tag_reg;

endmodule

[rtl/adsr_env_div.sv]
// pipelined restoring divider, one quotient bit per stage
module adsr_env_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  adsr_env_pkg::num_t  in_num,
    input  adsr_env_pkg::len_t  in_dv,
    input  adsr_env_pkg::tag_t  in_tag,
    output logic                out_valid,
    output adsr_env_pkg::lvl_t  out_quo,
    output adsr_env_pkg::tag_t  out_tag
);

    localparam int QW = adsr_env_pkg::QUO_W;
    localparam int NW = adsr_env_pkg::NUM_W;
    localparam int LW = adsr_env_pkg::LEN_W;

    // upper LW bits hold the partial remainder, lower QW bits the
    // unconsumed dividend with quotient bits shifting in behind
    logic               vld_reg [0:QW];
    adsr_env_pkg::num_t acc_reg [0:QW];
    adsr_env_pkg::len_t dv_reg  [0:QW];
    adsr_env_pkg::tag_t tag_reg [0:QW];
    adsr_env_pkg::num_t acc_next [0:QW-1];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_step
            logic [NW:0] sh;
            logic [LW:0] hi;
            logic [LW:0] diff;
            logic        take;

            assign sh   = {acc_reg[k], 1'b0};
            assign hi   = sh[NW -: LW+1];
            assign take = hi >= {1'b0, dv_reg[k]};
            assign diff = hi - {1'b0, dv_reg[k]};
            assign acc_next[k] = take ? {diff[LW-1:0], sh[QW-1:1], 1'b1}
                                      : {hi[LW-1:0], sh[QW-1:1], 1'b0};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n <= QW; n++)
            begin
                vld_reg[n] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int n = 0; n < QW; n++)
            begin
                vld_reg[n+1] <= vld_reg[n];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg[0] <= in_num;
        dv_reg[0]  <= in_dv;
        tag_reg[0] <= in_tag;
        for (int n = 0; n < QW; n++)
        begin
            acc_reg[n+1] <= acc_next[n];
            dv_reg[n+1]  <= dv_reg[n];
            tag_reg[n+1] <= tag_reg[n];
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_quo   = acc_reg[QW][QW-1:0];
    assign out_tag   = tag_reg[QW];

endmodule

[rtl/adsr_envelope_level.sv]
// top level: linear adsr envelope level per sample index, fully pipelined
// throughput: one transaction per clock while busy is low, set by the two bit-per-stage dividers
// busy is high during reset and in the first cycle after reset, and low from then on
// reset clears the pipeline valid bits and loads the default register values
// results leave as one-cycle strobes; the receiver cannot stall
module adsr_envelope_level (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [adsr_env_pkg::IDX_W-1:0]     sample_index,
    output logic                               result_valid,
    output logic [adsr_env_pkg::LVL_W-1:0]     level,
    output logic [2:0]                         phase,
    input  logic                               cfg_wr_en,
    input  logic [adsr_env_pkg::ADDR_W-1:0]    cfg_addr,
    input  logic [adsr_env_pkg::CFG_W-1:0]     cfg_wr_data
);

    // ------------------------------------------------------------------
    // configuration registers, stored already normalized:
    // zero lengths become one, sustain above full scale becomes full scale
    // ------------------------------------------------------------------
    adsr_env_pkg::cfg_t cfg_reg;
    adsr_env_pkg::len_t wr_len;
    adsr_env_pkg::lvl_t wr_lvl;

    assign wr_len = cfg_wr_data[adsr_env_pkg::LEN_W-1:0];
    assign wr_lvl = cfg_wr_data[adsr_env_pkg::LVL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack  <= adsr_env_pkg::ATTACK_RST;
            cfg_reg.decay   <= adsr_env_pkg::DECAY_RST;
            cfg_reg.rel_len <= adsr_env_pkg::RELEASE_RST;
            cfg_reg.sustain <= adsr_env_pkg::SUSTAIN_RST;
            cfg_reg.gate    <= adsr_env_pkg::GATE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                adsr_env_pkg::CFG_ATTACK_LEN:
                    cfg_reg.attack <= (wr_len == '0) ? adsr_env_pkg::len_t'(1) : wr_len;
                adsr_env_pkg::CFG_DECAY_LEN:
                    cfg_reg.decay <= (wr_len == '0) ? adsr_env_pkg::len_t'(1) : wr_len;
                adsr_env_pkg::CFG_RELEASE_LEN:
                    cfg_reg.rel_len <= (wr_len == '0) ? adsr_env_pkg::len_t'(1) : wr_len;
                adsr_env_pkg::CFG_SUSTAIN:
                    cfg_reg.sustain <= (wr_lvl > adsr_env_pkg::LEVEL_ONE)
                                       ? adsr_env_pkg::LEVEL_ONE : wr_lvl;
                adsr_env_pkg::CFG_GATE_OFF:
                    cfg_reg.gate <= cfg_wr_data[adsr_env_pkg::IDX_W-1:0];
                default:
                    ; // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // command handshake: busy only right out of reset
    // ------------------------------------------------------------------
    logic busy_reg;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    // ------------------------------------------------------------------
    // front end: pick x = index or gate-off index, find its segment,
    // and set up the held-level fraction as num / dv
    //   attack : ONE * x / A
    //   decay  : (ONE - S) * (x - A) / D
    //   sustain: S * 1 / 1
    // ------------------------------------------------------------------
    logic               fe_valid;
    adsr_env_pkg::lvl_t fe_a;
    adsr_env_pkg::len_t fe_b;
    adsr_env_pkg::len_t fe_dv;
    adsr_env_pkg::tag_t fe_tag;

    adsr_env_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_index  (sample_index),
        .cfg       (cfg_reg),
        .out_valid (fe_valid),
        .out_a     (fe_a),
        .out_b     (fe_b),
        .out_dv    (fe_dv),
        .out_tag   (fe_tag)
    );

    logic               sc1_valid;
    adsr_env_pkg::num_t sc1_num;
    adsr_env_pkg::len_t sc1_dv;
    adsr_env_pkg::tag_t sc1_tag;

    adsr_env_scale u_scale_held (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_a      (fe_a),
        .in_b      (fe_b),
        .in_dv     (fe_dv),
        .in_tag    (fe_tag),
        .out_valid (sc1_valid),
        .out_num   (sc1_num),
        .out_dv    (sc1_dv),
        .out_tag   (sc1_tag)
    );

    logic               dv1_valid;
    adsr_env_pkg::lvl_t dv1_quo;
    adsr_env_pkg::tag_t dv1_tag;

    adsr_env_div u_div_held (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sc1_valid),
        .in_num    (sc1_num),
        .in_dv     (sc1_dv),
        .in_tag    (sc1_tag),
        .out_valid (dv1_valid),
        .out_quo   (dv1_quo),
        .out_tag   (dv1_tag)
    );

    // ------------------------------------------------------------------
    // mid stage: held level L, then the release fraction
    //   release: L * (R - rel) / R
    //   done   : L * 0 / 1
    //   held   : L * 1 / 1 (passes L through unchanged)
    // ------------------------------------------------------------------
    logic               mid_vld_reg;
    adsr_env_pkg::lvl_t mid_a_reg;
    adsr_env_pkg::len_t mid_b_reg;
    adsr_env_pkg::len_t mid_dv_reg;
    adsr_env_pkg::tag_t mid_tag_reg;

    adsr_env_pkg::lvl_t held_next;
    adsr_env_pkg::len_t mb_next;
    adsr_env_pkg::len_t mdv_next;

    assign held_next = (dv1_tag.hseg == adsr_env_pkg::PH_DECAY)
                       ? adsr_env_pkg::LEVEL_ONE - dv1_quo : dv1_quo;

    always_comb
    begin
        unique case (dv1_tag.phase)
            adsr_env_pkg::PH_RELEASE:
            begin
                mb_next  = dv1_tag.rel_left;
                mdv_next = cfg_reg.rel_len;
            end
            adsr_env_pkg::PH_DONE:
            begin
                mb_next  = '0;
                mdv_next = adsr_env_pkg::len_t'(1);
            end
            default:
            begin
                mb_next  = adsr_env_pkg::len_t'(1);
                mdv_next = adsr_env_pkg::len_t'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_vld_reg <= 1'b0;
        end
        else
        begin
            mid_vld_reg <= dv1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_a_reg   <= held_next;
        mid_b_reg   <= mb_next;
        mid_dv_reg  <= mdv_next;
        mid_tag_reg <= dv1_tag;
    end

    logic               sc2_valid;
    adsr_env_pkg::num_t sc2_num;
    adsr_env_pkg::len_t sc2_dv;
    adsr_env_pkg::tag_t sc2_tag;

    adsr_env_scale u_scale_rel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_vld_reg),
        .in_a      (mid_a_reg),
        .in_b      (mid_b_reg),
        .in_dv     (mid_dv_reg),
        .in_tag    (mid_tag_reg),
        .out_valid (sc2_valid),
        .out_num   (sc2_num),
        .out_dv    (sc2_dv),
        .out_tag   (sc2_tag)
    );

    logic               dv2_valid;
    adsr_env_pkg::lvl_t dv2_quo;
    adsr_env_pkg::tag_t dv2_tag;

    adsr_env_div u_div_rel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sc2_valid),
        .in_num    (sc2_num),
        .in_dv     (sc2_dv),
        .in_tag    (sc2_tag),
        .out_valid (dv2_valid),
        .out_quo   (dv2_quo),
        .out_tag   (dv2_tag)
    );

    // result transaction straight from the last divider stage
    assign result_valid = dv2_valid;
    assign level        = dv2_quo;
    assign phase        = dv2_tag.phase;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid == $past(accept, adsr_env_pkg::PIPE_LAT))
        else $error("result strobe does not match accepted start");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (phase == adsr_env_pkg::PH_DONE) |-> level == '0)
        else $error("done segment with nonzero level");

    a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> level <= adsr_env_pkg::LEVEL_ONE)
        else $error("level above full scale");

    a_sustain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (phase == adsr_env_pkg::PH_SUSTAIN) |-> level == cfg_reg.sustain)
        else $error("sustain segment level differs from sustain register");

    a_attack: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (phase == adsr_env_pkg::PH_ATTACK)
            |-> level < adsr_env_pkg::LEVEL_ONE)
        else $error("attack segment reached full scale");

endmodule

[dv/tb_adsr_envelope_level.sv]
// self-checking testbench for the adsr envelope level block: directed and random index sweeps
`timescale 1ns / 1ps

module tb_adsr_envelope_level;

    import adsr_env_pkg::*;

    // full scale as a wide integer, so the predictor math never overflows
    localparam longint unsigned FULL_SCALE = 64'd1 << LEVEL_FRAC_BITS;
    // bound on the whole run
    localparam int CYCLE_LIMIT = 100000;
    localparam int RAND_PHASES = 10;
    localparam int RAND_ITEMS  = 50;

    typedef struct {
        lvl_t   level;
        phase_t phase;
    } env_point_t;

    logic               clk;
    logic               rst_n;
    logic               start = 1'b0;
    logic               busy;
    idx_t               sample_index = '0;
    logic               result_valid;
    lvl_t               level;
    logic [2:0]         phase;
    logic               cfg_wr_en;
    logic [ADDR_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]   cfg_wr_data;

    // register shadow, raw as written; lengths of zero and sustain overflow
    // are resolved inside the predictor
    len_t attack_r  = ATTACK_RST;
    len_t decay_r   = DECAY_RST;
    len_t release_r = RELEASE_RST;
    lvl_t sustain_r = SUSTAIN_RST;
    idx_t gate_r    = GATE_RST;

    // indexes on and around every segment edge of the directed setup
    int seg_edges [14] = '{0, 1, 50, 99, 100, 101, 299, 300, 301, 999, 1000, 1001,
                           1299, 1300};

    idx_t       pending_idx_q[$];   // indexes waiting to be driven
    env_point_t env_exp_q[$];       // predicted levels, oldest first
    int         n_queued  = 0;
    int         n_taken   = 0;
    int         err_cnt   = 0;
    int         cycle_cnt = 0;
    int         idle_pct  = 30;
    logic       took_item = 1'b0;   // start transaction accepted at the last rising edge

    adsr_envelope_level DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample_index (sample_index),
        .result_valid (result_valid),
        .level        (level),
        .phase        (phase),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // envelope predictor
    // ------------------------------------------------------------------

    // a length register of zero behaves as a length of one
    function automatic longint unsigned eff_len(input len_t v);
        return (v == '0) ? 64'd1 : 64'(v);
    endfunction

    // level while the gate is still open: attack ramp, decay ramp or sustain hold
    function automatic longint unsigned pre_gate_level(
        input  longint unsigned x,
        input  longint unsigned a,
        input  longint unsigned d,
        input  longint unsigned s,
        output phase_t          seg
    );
        if (x < a)
        begin
            seg = PH_ATTACK;
            return (x * FULL_SCALE) / a;
        end
        if (x - a < d)
        begin
            seg = PH_DECAY;
            return FULL_SCALE - ((FULL_SCALE - s) * (x - a)) / d;
        end
        seg = PH_SUSTAIN;
        return s;
    endfunction

    function automatic env_point_t envelope_at(input idx_t idx);
        longint unsigned a, d, r, s, x, g, rel, from_lvl;
        phase_t          seg, gate_seg;
        env_point_t      pt;
        a = eff_len(attack_r);
        d = eff_len(decay_r);
        r = eff_len(release_r);
        // sustain values above full scale clamp to full scale
        s = (64'(sustain_r) > FULL_SCALE) ? FULL_SCALE : 64'(sustain_r);
        x = 64'(idx);
        g = 64'(gate_r);
        if (x < g)
        begin
            pt.level = lvl_t'(pre_gate_level(x, a, d, s, seg));
            pt.phase = seg;
        end
        else
        begin
            rel = x - g;
            if (rel >= r)
            begin
                pt.level = '0;
                pt.phase = PH_DONE;
            end
            else
            begin
                // release starts from whatever level the envelope had at gate-off
                from_lvl = pre_gate_level(g, a, d, s, gate_seg);
                pt.level = lvl_t'((from_lvl * (r - rel)) / r);
                pt.phase = PH_RELEASE;
            end
        end
        return pt;
    endfunction

    // ------------------------------------------------------------------
    // driver: one start transaction per item, random idle cycles between
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || took_item)
        begin
            if (pending_idx_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                start        <= 1'b1;
                sample_index <= pending_idx_q.pop_front();
            end
            else
            begin
                // idle cycle: index wiggles with start low and must be ignored
                start        <= 1'b0;
                sample_index <= idx_t'($urandom());
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on accept, check each result strobe in order
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        env_point_t exp_pt;
        if (!rst_n)
        begin
            took_item <= 1'b0;
        end
        else
        begin
            if (result_valid)
            begin
                if (env_exp_q.size() == 0)
                begin
                    $error("result with no transaction outstanding: level %0d phase %0d",
                           level, phase);
                    err_cnt++;
                end
                else
                begin
                    exp_pt = env_exp_q.pop_front();
                    if (level !== exp_pt.level)
                    begin
                        $error("level mismatch: expected %0d, got %0d", exp_pt.level, level);
                        err_cnt++;
                    end
                    if (phase !== exp_pt.phase)
                    begin
                        $error("phase mismatch: expected %0d, got %0d", exp_pt.phase, phase);
                        err_cnt++;
                    end
                end
            end
            took_item <= start && !busy;
            if (start && !busy)
            begin
                env_exp_q.push_back(envelope_at(sample_index));
                n_taken++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_item(input idx_t idx);
        pending_idx_q.push_back(idx);
        n_queued++;
    endtask

    // returns on a falling edge once every queued item is accepted and answered
    task automatic wait_idle();
        do
            @(negedge clk);
        while (n_taken != n_queued || env_exp_q.size() != 0);
    endtask

    // called on a falling edge; leaves the write enable high for the caller to drop
    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        case (addr)
            CFG_ATTACK_LEN:  attack_r  = data[LEN_W-1:0];
            CFG_DECAY_LEN:   decay_r   = data[LEN_W-1:0];
            CFG_RELEASE_LEN: release_r = data[LEN_W-1:0];
            CFG_SUSTAIN:     sustain_r = data[LVL_W-1:0];
            CFG_GATE_OFF:    gate_r    = data[IDX_W-1:0];
            default: ;  // unmapped index, no register changes
        endcase
        @(negedge clk);
    endtask

    task automatic load_config(
        input logic [CFG_W-1:0] a,
        input logic [CFG_W-1:0] d,
        input logic [CFG_W-1:0] r,
        input logic [CFG_W-1:0] s,
        input logic [CFG_W-1:0] g
    );
        reg_write(CFG_ATTACK_LEN, a);
        reg_write(CFG_DECAY_LEN, d);
        reg_write(CFG_RELEASE_LEN, r);
        reg_write(CFG_SUSTAIN, s);
        reg_write(CFG_GATE_OFF, g);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly short segments so random indexes land in every segment
    function automatic logic [CFG_W-1:0] pick_len();
        case ($urandom_range(0, 5))
            0:       return CFG_W'($urandom_range(0, 1));
            1, 2:    return CFG_W'($urandom_range(1, 40));
            3:       return CFG_W'($urandom_range(1, 3000));
            4:       return CFG_W'($urandom_range(1, 160000));
            default: return CFG_W'($urandom());  // bits above the register width get dropped
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_sustain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_W'(FULL_SCALE);
            2:       return CFG_W'($urandom_range(65537, 131071));
            3:       return CFG_W'($urandom());
            default: return CFG_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic load_random_config();
        logic [CFG_W-1:0] gate_v;
        reg_write(CFG_ATTACK_LEN, pick_len());
        reg_write(CFG_DECAY_LEN, pick_len());
        reg_write(CFG_RELEASE_LEN, pick_len());
        reg_write(CFG_SUSTAIN, pick_sustain());
        // gate-off anywhere in attack, decay or sustain, at zero, or anywhere at all
        case ($urandom_range(0, 5))
            0:       gate_v = '0;
            1:       gate_v = CFG_W'($urandom());
            default: gate_v = CFG_W'($urandom_range(0,
                                  32'(eff_len(attack_r) + eff_len(decay_r) + 8)));
        endcase
        reg_write(CFG_GATE_OFF, gate_v);
        if ($urandom_range(0, 2) == 0)
            reg_write(ADDR_W'(CFG_GATE_OFF + $urandom_range(1, 3)), CFG_W'($urandom()));
        cfg_wr_en <= 1'b0;
    endtask

    // indexes cluster around segment boundaries, with some spread over the full range
    function automatic idx_t pick_index();
        longint unsigned a, d, r, g, anchor;
        a = eff_len(attack_r);
        d = eff_len(decay_r);
        r = eff_len(release_r);
        g = 64'(gate_r);
        case ($urandom_range(0, 9))
            0, 1:    return idx_t'($urandom());
            2:       anchor = 0;
            3:       anchor = a;
            4:       anchor = a + d;
            5, 6:    anchor = g;
            7:       anchor = g + r;
            default: anchor = $urandom_range(0, 32'(a + d + g + r + 8));
        endcase
        return idx_t'(anchor + $urandom_range(0, 16) - 8);
    endfunction

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= CFG_ATTACK_LEN;
        cfg_wr_data <= '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // reset registers: gate-off at zero, so everything is release from level 0 or done
        queue_item(idx_t'(0));
        queue_item(idx_t'(6399));
        queue_item(idx_t'(6400));
        queue_item(idx_t'(20'hFFFFF));
        wait_idle();

        // zero lengths act as one, sustain above full scale clamps
        load_config('0, '0, '0, CFG_W'(131071), CFG_W'(1));
        queue_item(idx_t'(0));
        queue_item(idx_t'(1));
        queue_item(idx_t'(2));
        wait_idle();

        // every segment and its edges
        load_config(CFG_W'(100), CFG_W'(200), CFG_W'(300), CFG_W'(30000), CFG_W'(1000));
        foreach (seg_edges[k])
            queue_item(idx_t'(seg_edges[k]));
        wait_idle();

        // largest register values, gate-off at the top index
        load_config(20'hFFFFF, 20'h3FFFF, CFG_W'(262143), CFG_W'(65536), 20'hFFFFF);
        queue_item(idx_t'(262142));
        queue_item(idx_t'(20'hFFFFE));
        queue_item(idx_t'(20'hFFFFF));
        wait_idle();

        // random settings; each phase boundary drains the pipe before rewriting registers
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            load_random_config();
            idle_pct = (p == 4) ? 0 : 30;  // one back-to-back stretch
            for (int n = 0; n < RAND_ITEMS; n++)
                queue_item(pick_index());
            wait_idle();
        end

        // any stray strobe would show up within one pipeline depth
        repeat (PIPE_LAT + 8) @(posedge clk);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
